/* rtl/core/lru_lookup_cache_defines.svh */
// Assertion macros shared by the cache checker.
`ifndef LRU_LOOKUP_CACHE_DEFINES_SVH
`define LRU_LOOKUP_CACHE_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define LRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LRC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/lrc_pkg.sv */
// Shared constants, types and helpers for the LRU lookup cache.
`default_nettype none

package lrc_pkg;

  localparam int ENTRIES    = 64;
  localparam int DATA_WIDTH = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int RANK_W     = IDX_W;
  localparam int KEY_W      = 64;
  localparam int WORD_W     = 64;
  localparam int CAP_W      = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [1:0] {
    OP_SEARCH  = 2'd0,
    OP_PROMOTE = 2'd1,
    OP_INSERT  = 2'd2
  } op_t;

  typedef struct packed {
    logic start;
    logic clr_idx;
    logic issue;
    op_t  op;
    logic pay_rd;
    logic slot_wr;
    logic load_out;
  } lrc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rd_busy;
    logic found;
    logic full;
    logic out_free;
  } lrc_status_t;

  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (cap == '0) begin
      res = CNT_W'(1);
    end else if (int'(cap) > ENTRIES) begin
      res = CNT_W'(ENTRIES);
    end else begin
      res = CNT_W'(cap);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lrc_ctrl.sv */
// Control state machine sequencing the search, promote and insert passes.
`default_nettype none

module lrc_ctrl
  import lrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        mode,
  output logic        s_tready,
  input  lrc_status_t status,
  output lrc_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRCH = 5'b00010,
    S_PROM = 5'b00100,
    S_INS  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_SEARCH;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = (mode == MODE_INSERT) ? S_INS : S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.op = OP_SEARCH;
        if (!status.scan_done) begin
          cmd.issue = 1'b1;
        end else if (!status.rd_busy) begin
          if (status.found) begin
            cmd.pay_rd  = 1'b1;
            cmd.clr_idx = 1'b1;
            state_next  = S_PROM;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_PROM: begin
        cmd.op = OP_PROMOTE;
        if (!status.scan_done) begin
          cmd.issue = 1'b1;
        end else if (!status.rd_busy) begin
          state_next = S_FIN;
        end
      end
      S_INS: begin
        cmd.op = OP_INSERT;
        if (!status.scan_done) begin
          cmd.issue = 1'b1;
        end else if (!status.rd_busy) begin
          cmd.slot_wr = !status.full;
          state_next  = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/lrc_dpath.sv */
// Datapath: tag, payload and rank memories, scan pipeline and result register.
`default_nettype none

module lrc_dpath
  import lrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  lrc_cmd_t           cmd,
  output lrc_status_t        status,
  input  logic               in_mode,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [WORD_W-1:0]  in_data,
  input  logic               cap_wr_en,
  input  logic [CAP_W-1:0]   cap_wr_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [WORD_W-1:0]  out_data,
  output logic               out_evict
);

  logic [KEY_W-1:0]      tag_mem [ENTRIES];
  logic [DATA_WIDTH-1:0] pay_mem [ENTRIES];
  logic [RANK_W-1:0]     rank_mem [ENTRIES];

  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      idx;
  logic                  rd_valid;
  op_t                   rd_op;
  logic [IDX_W-1:0]      rd_idx;
  logic [KEY_W-1:0]      tag_q;
  logic [RANK_W-1:0]     rank_q;
  logic [DATA_WIDTH-1:0] pay_q;
  logic                  found;
  logic                  full_q;
  logic [IDX_W-1:0]      best;
  logic [RANK_W-1:0]     best_rank;
  logic                  mode_q;
  logic [KEY_W-1:0]      key_q;
  logic [DATA_WIDTH-1:0] data_q;

  logic                  rank_we;
  logic [IDX_W-1:0]      rank_waddr;
  logic [RANK_W-1:0]     rank_wdata;
  logic                  tp_we;
  logic [IDX_W-1:0]      tp_waddr;
  logic [RANK_W-1:0]     last_rank;
  logic                  match;

  assign last_rank = RANK_W'(fill - CNT_W'(1));
  assign match     = rd_valid && (rd_op == OP_SEARCH) && (tag_q == key_q) &&
                     (!found || (rank_q < best_rank));

  assign status.scan_done = (idx == fill);
  assign status.rd_busy   = rd_valid;
  assign status.found     = found;
  assign status.full      = full_q;
  assign status.out_free  = !out_valid || out_ready;

  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = rd_idx;
    rank_wdata = '0;
    tp_we      = 1'b0;
    tp_waddr   = rd_idx;
    if (rd_valid) begin
      unique case (rd_op)
        OP_SEARCH: begin
          rank_we = 1'b0;
        end
        OP_PROMOTE: begin
          rank_we = 1'b1;
          if (rd_idx == best) begin
            rank_wdata = '0;
          end else if (rank_q < best_rank) begin
            rank_wdata = rank_q + RANK_W'(1);
          end else begin
            rank_wdata = rank_q;
          end
        end
        OP_INSERT: begin
          rank_we = 1'b1;
          if (full_q && (rank_q == last_rank)) begin
            tp_we      = 1'b1;
            rank_wdata = '0;
          end else begin
            rank_wdata = rank_q + RANK_W'(1);
          end
        end
        default: begin
          rank_we = 1'b0;
        end
      endcase
    end
    if (cmd.slot_wr) begin
      rank_we    = 1'b1;
      rank_waddr = fill[IDX_W-1:0];
      rank_wdata = '0;
      tp_we      = 1'b1;
      tp_waddr   = fill[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tp_we) begin
      tag_mem[tp_waddr] <= key_q;
      pay_mem[tp_waddr] <= data_q;
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    if (cmd.issue) begin
      tag_q  <= tag_mem[idx[IDX_W-1:0]];
      rank_q <= rank_mem[idx[IDX_W-1:0]];
    end
    if (cmd.pay_rd) begin
      pay_q <= pay_mem[best];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      fill      <= '0;
      idx       <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
      full_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cap_wr_en) begin
        capacity <= cap_wr_data;
      end
      if (cmd.slot_wr) begin
        fill <= fill + CNT_W'(1);
      end
      rd_valid <= cmd.issue;
      if (cmd.start || cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.issue) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.start) begin
        found  <= 1'b0;
        full_q <= (fill >= eff_capacity(capacity));
      end else if (match) begin
        found <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_op  <= cmd.op;
    rd_idx <= idx[IDX_W-1:0];
    if (match) begin
      best      <= rd_idx;
      best_rank <= rank_q;
    end
    if (cmd.start) begin
      mode_q <= in_mode;
      key_q  <= in_key;
      data_q <= in_data[DATA_WIDTH-1:0];
    end
    if (cmd.load_out) begin
      out_hit   <= (mode_q == MODE_LOOKUP) && found;
      out_data  <= ((mode_q == MODE_LOOKUP) && found) ? WORD_W'(pay_q) : '0;
      out_evict <= (mode_q == MODE_INSERT) && full_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lru_lookup_cache.sv */
// Each transaction scans the F filled entries, F the fill count at accept; a lookup hit
// scans them once more to promote the entry found, so it takes longer than a miss or an insert.
// One transaction in flight; the next is taken in the cycle after the result is loaded,
// so the transaction period is set by the memory scan;
// a result still held by m_tready delays the load of the next result.
// Synchronous reset empties the cache (fill count zero), sets capacity to 64, clears no memory.
`default_nettype none

module lru_lookup_cache
  import lrc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [KEY_W+WORD_W-1:0]   s_tdata,   // key, data_in
  input  logic                      s_tuser,   // mode
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [WORD_W-1:0]         m_tdata,   // data_out
  output logic [1:0]                m_tuser,   // hit, evicted
  input  logic                      cfg_wr_en,
  input  logic [CAP_W-1:0]          cfg_wr_data
);

  lrc_cmd_t    cmd;
  lrc_status_t status;
  logic        out_hit;
  logic        out_evict;

  lrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lrc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_mode     (s_tuser),
    .in_key      (s_tdata[KEY_W-1:0]),
    .in_data     (s_tdata[KEY_W+WORD_W-1:KEY_W]),
    .cap_wr_en   (cfg_wr_en),
    .cap_wr_data (cfg_wr_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_hit     (out_hit),
    .out_data    (m_tdata),
    .out_evict   (out_evict)
  );

  assign m_tuser = {out_evict, out_hit};

endmodule

`default_nettype wire

/* rtl/core/lrc_checker.sv */
// Port-level checker for the LRU lookup cache, bound to the top level.
`default_nettype none
`include "lru_lookup_cache_defines.svh"

module lrc_checker
  import lrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [WORD_W-1:0] m_tdata,
  input  logic [1:0]        m_tuser
);

  `LRC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `LRC_ASSERT(a_hit_evict_excl, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "hit and evicted both set")
  `LRC_ASSERT(a_miss_zero, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "nonzero data without hit")
  `LRC_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "second transaction taken during work")
  `LRC_ASSERT_RST(a_reset_idle, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind lru_lookup_cache lrc_checker u_lrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

/* dv/lru_lookup_cache_checker.sv */
// Checker for the LRU lookup cache: tracks cache contents and compares every result.
`default_nettype none

module lru_lookup_cache_checker
  import lrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [KEY_W+WORD_W-1:0] s_tdata,
  input  logic                    s_tuser,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [WORD_W-1:0]       m_tdata,
  input  logic [1:0]              m_tuser,
  input  logic                    cfg_wr_en,
  input  logic [CAP_W-1:0]        cfg_wr_data,
  output int                      error_count,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] data_out;
    logic              evicted;
  } cache_result_t;

  logic [KEY_W-1:0]  tag_mem [ENTRIES];
  logic [WORD_W-1:0] pay_mem [ENTRIES];
  int                age_rank [ENTRIES];
  int                filled = 0;
  logic [CAP_W-1:0]  capacity = CAP_RESET;
  cache_result_t     pending_results [$];
  int                mismatches = 0;
  int                pending_n = 0;

  assign error_count = mismatches;
  assign outstanding = pending_n;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int allowed_entries();
    if (capacity == '0) begin
      return 1;
    end
    if (int'(capacity) > ENTRIES) begin
      return ENTRIES;
    end
    return int'(capacity);
  endfunction

  function automatic void make_most_recent(input int sel);
    int old;
    old = age_rank[sel];
    for (int i = 0; i < filled; i++) begin
      if (age_rank[i] < old) begin
        age_rank[i]++;
      end
    end
    age_rank[sel] = 0;
  endfunction

  function automatic cache_result_t access_cache(input logic mode, input logic [KEY_W-1:0] key,
                                                 input logic [WORD_W-1:0] data);
    cache_result_t r;
    int            sel;
    int            worst;
    logic          found;
    r = '0;
    sel = 0;
    worst = 0;
    found = 1'b0;
    if (mode == MODE_LOOKUP) begin
      for (int i = 0; i < filled; i++) begin
        if (tag_mem[i] == key && (!found || age_rank[i] < age_rank[sel])) begin
          found = 1'b1;
          sel = i;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.data_out = pay_mem[sel];
        make_most_recent(sel);
      end
    end else if (filled >= allowed_entries()) begin
      for (int i = 0; i < filled; i++) begin
        if (age_rank[i] >= worst) begin
          worst = age_rank[i];
          sel = i;
        end
      end
      tag_mem[sel] = key;
      pay_mem[sel] = data;
      make_most_recent(sel);
      r.evicted = 1'b1;
    end else begin
      for (int i = 0; i < filled; i++) begin
        age_rank[i]++;
      end
      tag_mem[filled] = key;
      pay_mem[filled] = data;
      age_rank[filled] = 0;
      filled++;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cache_result_t want;
    if (rst) begin
      filled = 0;
      capacity = CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        age_rank[i] = 0;
      end
      pending_results.delete();
      pending_n <= 0;
    end else begin
      if (cfg_wr_en) begin
        capacity = cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(access_cache(s_tuser, s_tdata[KEY_W-1:0],
                                               s_tdata[KEY_W +: WORD_W]));
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = pending_results.pop_front();
          if (m_tuser[0] !== want.hit) begin
            report_mismatch($sformatf("hit %b, want %b", m_tuser[0], want.hit));
          end
          if (m_tdata !== want.data_out) begin
            report_mismatch($sformatf("data_out %h, want %h", m_tdata, want.data_out));
          end
          if (m_tuser[1] !== want.evicted) begin
            report_mismatch($sformatf("evicted %b, want %b", m_tuser[1], want.evicted));
          end
        end
      end
      pending_n <= pending_results.size();
    end
  end

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Top of the LRU lookup cache testbench: clock, reset, stimulus and verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lrc_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [KEY_W+WORD_W-1:0] s_tdata = '0;
  logic                    s_tuser = MODE_LOOKUP;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [WORD_W-1:0]       m_tdata;
  logic [1:0]              m_tuser;
  logic                    cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]        cfg_wr_data = '0;
  int                      error_count;
  int                      outstanding;

  int                      src_idle_pct = 0;
  int                      sink_stall_pct = 0;
  logic [KEY_W-1:0]        key_pool [$];
  int                      phase_caps [8] = '{64, 1, 127, 0, 40, 64, 3, 100};

  always #5 clk = ~clk;

  lru_lookup_cache dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lru_lookup_cache_checker cache_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(input logic mode, input logic [KEY_W-1:0] key,
                           input logic [WORD_W-1:0] data);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {data, key};
    do @(posedge clk); while (!s_tready);
    if (mode == MODE_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 96) begin
        void'(key_pool.pop_front());
      end
    end
  endtask

  // hold the sender until every transaction has returned its result
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_item();
    logic [KEY_W-1:0]  k;
    logic [WORD_W-1:0] d;
    int                pick;
    int                n;
    d = {$urandom, $urandom};
    pick = $urandom_range(99);
    n = key_pool.size();
    if ($urandom_range(9) == 0) begin
      k = KEY_W'($urandom_range(15));
    end else begin
      k = {$urandom, $urandom};
    end
    if (n > 0 && (pick < 9 || (pick >= 45 && pick < 85))) begin
      if ($urandom_range(1) == 0) begin
        k = key_pool[n - 1 - $urandom_range((n < 4) ? n - 1 : 3)];
      end else begin
        k = key_pool[$urandom_range(n - 1)];
      end
    end
    send_item((pick < 45) ? MODE_INSERT : MODE_LOOKUP, k, d);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_item(MODE_LOOKUP, '0, '1);
    send_item(MODE_INSERT, '0, '1);
    send_item(MODE_INSERT, '1, '0);
    send_item(MODE_INSERT, 64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555);
    send_item(MODE_INSERT, 64'h0123_4567_89AB_CDEF, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(MODE_LOOKUP, '1, 64'h1);
    send_item(MODE_LOOKUP, '0, '0);
    send_item(MODE_INSERT, '0, 64'hDEAD_BEEF_0BAD_F00D);
    send_item(MODE_LOOKUP, '0, '0);
    send_item(MODE_LOOKUP, 64'h1, '0);
    drain();
    set_capacity(CAP_W'(2));
    send_item(MODE_INSERT, 64'h7, 64'h7777);
    send_item(MODE_INSERT, 64'h8, 64'h8888);
    send_item(MODE_LOOKUP, 64'h8000_0000_0000_0001, '0);
    send_item(MODE_LOOKUP, 64'h7, '0);
    drain();
    set_capacity(CAP_W'(0));
    send_item(MODE_INSERT, 64'h9, 64'h9999);
    send_item(MODE_LOOKUP, 64'h9, '0);
    send_item(MODE_LOOKUP, 64'h8, '0);
    drain();
    set_capacity(CAP_W'(127));
    send_item(MODE_INSERT, 64'hA, '1);
    send_item(MODE_LOOKUP, 64'hA, '0);
    send_item(MODE_LOOKUP, '1, '0);

    for (int p = 0; p < 8; p++) begin
      drain();
      set_capacity(CAP_W'(phase_caps[p]));
      case (p % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 49;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 49;
        end
        default: begin
          src_idle_pct = 31;
          sink_stall_pct = 31;
        end
      endcase
      repeat (210) begin
        random_item();
        if ($urandom_range(99) == 0) begin
          drain();
        end
      end
    end

    drain();
    repeat (140) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
